// ===== src/chme_pkg.sv =====
// Shared types and constants for the chained hash map engine.
`default_nettype none

package chme_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;

    localparam int BUCKET_COUNT_DEF = 64;
    localparam int NODE_COUNT_DEF   = 256;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD,
        S_WALK,
        S_FREE,
        S_INS,
        S_DEL1,
        S_DEL2,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/chme_req_if.sv =====
// Request channel: operation, key and value to store.
`default_nettype none

interface chme_req_if
    import chme_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value_in;

    modport source (output valid, output mode, output key, output value_in, input ready);
    modport sink   (input valid, input mode, input key, input value_in, output ready);
endinterface

`default_nettype wire

// ===== src/chme_rsp_if.sv =====
// Response channel: status and looked-up value.
`default_nettype none

interface chme_rsp_if
    import chme_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [VALUE_W-1:0] value_out;

    modport source (output valid, output status, output value_out, input ready);
    modport sink   (input valid, input status, input value_out, output ready);
endinterface

`default_nettype wire

// ===== src/chained_hash_map_engine_core.sv =====
// Chained hash map engine: key-to-value map with separate chaining over a node pool.
//
// Usage
//   i_req carries one operation per transaction: mode (0 insert, 1 lookup,
//   2 delete), a 32-bit key and, for insert, a 64-bit value. o_rsp returns
//   one transaction per request: status (0 ok, 1 duplicate, 2 pool full,
//   3 not found) and value_out (stored value on a lookup hit, else 0).
//   One operation is in flight at a time; i_req.ready is high while idle.
//   Steps per operation, accept to next accept: bucket head read, chain walk
//   node by node, then for an insert a free-list pop when one is used and the
//   node and head write, or for a delete the unlink and the free-list push.
//   An unused mode goes straight to the response. The response register
//   loads as the engine returns to idle. With a bucket count that is not a
//   power of two the bucket index comes from a reciprocal multiplication and
//   one correction. The node memory read per chain node sets the pace.
//   Reset: a clearing pass writes every bucket head to empty, one bucket
//   per cycle; requests wait until it ends.
//   Stall: the response sits in an output register; a new request is taken
//   while it waits, and the next result holds in the engine until it drains.
`default_nettype none

module chained_hash_map_engine_core
    import chme_pkg::*;
#(
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
    parameter int NODE_COUNT   = NODE_COUNT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    chme_req_if.sink    i_req,
    chme_rsp_if.source  o_rsp
);

    // widths: bucket index, node index, link (node index + 1, 0 = none)
    localparam int  BW     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int  NW     = $clog2(NODE_COUNT);
    localparam int  LW     = $clog2(NODE_COUNT + 1);
    localparam int  BITW   = 2;
    localparam int  PW     = 2 * KEY_W;
    localparam int  NODE_W = KEY_W + VALUE_W + LW;
    localparam bit  POW2   = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
    // floor(2^32 / BUCKET_COUNT)
    localparam logic [PW-1:0] RECIP = (PW'(1) << KEY_W) / PW'(BUCKET_COUNT);

    function automatic logic link_ok(input logic [LW-1:0] l);
        link_ok = (l != '0) && (l <= LW'(NODE_COUNT));
    endfunction

    function automatic logic [NW-1:0] to_idx(input logic [LW-1:0] l);
        logic [LW-1:0] d;
        d      = l - LW'(1);
        to_idx = d[NW-1:0];
    endfunction

    // memories: bucket heads and node words {key, value, next}
    logic [LW-1:0]     bkt_mem  [BUCKET_COUNT];
    logic [NODE_W-1:0] node_mem [NODE_COUNT];

    logic              bkt_we, bkt_re, node_we, node_re;
    logic [BW-1:0]     bkt_waddr, bkt_raddr;
    logic [LW-1:0]     bkt_wdata;
    logic [NW-1:0]     node_waddr, node_raddr;
    logic [NODE_W-1:0] node_wdata;

    logic [LW-1:0]     r_bkt_rd;
    logic [NODE_W-1:0] r_node_rd;

    // control and payload registers
    t_state             r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [BW-1:0]      r_bkt, n_bkt;
    logic [KEY_W-1:0]   r_quo, n_quo;
    logic [BITW-1:0]    r_bit, n_bit;
    logic [LW-1:0]      r_head, n_head;
    logic [LW-1:0]      r_cur, n_cur;
    logic [LW-1:0]      r_prev, n_prev;
    logic [NODE_W-1:0]  r_prev_word, n_prev_word;
    logic [LW-1:0]      r_steps, n_steps;
    logic [NW-1:0]      r_idx, n_idx;
    logic [LW-1:0]      r_free_head, n_free_head;
    logic [LW-1:0]      r_used, n_used;
    logic [1:0]         r_status, n_status;
    logic [VALUE_W-1:0] r_vout, n_vout;
    logic [BW-1:0]      r_clr, n_clr;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_status, n_out_status;
    logic [VALUE_W-1:0] r_out_vout, n_out_vout;

    // decode of the node word just read
    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_val;
    logic [LW-1:0]      rd_next;
    assign rd_key  = r_node_rd[NODE_W-1 -: KEY_W];
    assign rd_val  = r_node_rd[LW +: VALUE_W];
    assign rd_next = r_node_rd[LW-1:0];

    logic req_acc, mode_ok, hit, nxt_ok, head_ok, free_ok, pool_left, out_free;
    logic [PW-1:0]    mod_prod;
    logic [KEY_W-1:0] mod_qb, mod_diff, mod_bkt;
    t_state           miss_state;

    assign req_acc   = i_req.valid && i_req.ready;
    assign mode_ok   = (i_req.mode == MODE_INSERT) || (i_req.mode == MODE_LOOKUP)
                    || (i_req.mode == MODE_DELETE);
    assign hit       = rd_key == r_key;
    assign nxt_ok    = link_ok(rd_next) && (r_steps < LW'(NODE_COUNT));
    assign head_ok   = link_ok(r_bkt_rd);
    assign free_ok   = link_ok(r_free_head);
    assign pool_left = r_used < LW'(NODE_COUNT);
    assign out_free  = !r_out_valid || o_rsp.ready;

    // bucket index in three steps: quotient estimate (exact or one short),
    // its product with the bucket count, then difference and one correction
    assign mod_prod = PW'(r_key) * RECIP;
    assign mod_qb   = r_quo * KEY_W'(BUCKET_COUNT);
    assign mod_diff = r_key - r_quo;
    assign mod_bkt  = (mod_diff >= KEY_W'(BUCKET_COUNT)) ? mod_diff - KEY_W'(BUCKET_COUNT)
                                                         : mod_diff;

    // where a walk ends without finding the key
    always_comb begin
        miss_state = S_DONE;
        if (r_mode == MODE_INSERT) begin
            if (free_ok) begin
                miss_state = S_FREE;
            end else if (pool_left) begin
                miss_state = S_INS;
            end
        end
    end

    assign i_req.ready     = r_state == S_IDLE;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.value_out = r_out_vout;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == BW'(BUCKET_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_acc) begin
                    if (!mode_ok)  n_state = S_DONE;
                    else if (POW2) n_state = S_HEAD;
                    else           n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_bit == '0) n_state = S_HEAD;
            end
            S_HEAD: begin
                n_state = head_ok ? S_WALK : miss_state;
            end
            S_WALK: begin
                if (hit)         n_state = (r_mode == MODE_DELETE) ? S_DEL1 : S_DONE;
                else if (nxt_ok) n_state = S_WALK;
                else             n_state = miss_state;
            end
            S_FREE:  n_state = S_INS;
            S_INS:   n_state = S_DONE;
            S_DEL1:  n_state = S_DEL2;
            S_DEL2:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls and datapath
    always_comb begin
        bkt_we       = 1'b0;
        bkt_re       = 1'b0;
        bkt_waddr    = r_bkt;
        bkt_raddr    = r_bkt;
        bkt_wdata    = '0;
        node_we      = 1'b0;
        node_re      = 1'b0;
        node_waddr   = r_idx;
        node_raddr   = r_idx;
        node_wdata   = '0;
        n_mode       = r_mode;
        n_key        = r_key;
        n_val        = r_val;
        n_bkt        = r_bkt;
        n_quo        = r_quo;
        n_bit        = r_bit;
        n_head       = r_head;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_prev_word  = r_prev_word;
        n_steps      = r_steps;
        n_idx        = r_idx;
        n_free_head  = r_free_head;
        n_used       = r_used;
        n_status     = r_status;
        n_vout       = r_vout;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_vout   = r_out_vout;

        unique case (r_state)
            S_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr;
                n_clr     = r_clr + BW'(1);
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_mode   = i_req.mode;
                    n_key    = i_req.key;
                    n_val    = i_req.value_in;
                    n_bkt    = i_req.key[BW-1:0];
                    n_bit    = BITW'(2);
                    n_status = ST_MISS;
                    n_vout   = '0;
                    if (POW2 && mode_ok) begin
                        bkt_re    = 1'b1;
                        bkt_raddr = i_req.key[BW-1:0];
                    end
                end
            end
            S_MOD: begin
                n_bit = r_bit - BITW'(1);
                if (r_bit == BITW'(2)) begin
                    n_quo = mod_prod[PW-1:KEY_W];
                end else if (r_bit == BITW'(1)) begin
                    n_quo = mod_qb;
                end else begin
                    n_bkt     = mod_bkt[BW-1:0];
                    bkt_re    = 1'b1;
                    bkt_raddr = mod_bkt[BW-1:0];
                end
            end
            S_HEAD, S_WALK: begin
                if (r_state == S_HEAD && head_ok) begin
                    n_head     = r_bkt_rd;
                    n_prev     = '0;
                    n_steps    = LW'(1);
                    n_cur      = r_bkt_rd;
                    node_re    = 1'b1;
                    node_raddr = to_idx(r_bkt_rd);
                end else if (r_state == S_WALK && hit) begin
                    case (r_mode)
                        MODE_INSERT: n_status = ST_DUP;
                        MODE_LOOKUP: begin
                            n_status = ST_OK;
                            n_vout   = rd_val;
                        end
                        default: ;
                    endcase
                end else if (r_state == S_WALK && nxt_ok) begin
                    n_prev      = r_cur;
                    n_prev_word = r_node_rd;
                    n_cur       = rd_next;
                    n_steps     = r_steps + LW'(1);
                    node_re     = 1'b1;
                    node_raddr  = to_idx(rd_next);
                end else begin
                    // key absent: an insert takes a node if one is left
                    if (r_state == S_HEAD) n_head = r_bkt_rd;
                    if (r_mode == MODE_INSERT) begin
                        if (free_ok) begin
                            node_re    = 1'b1;
                            node_raddr = to_idx(r_free_head);
                        end else if (pool_left) begin
                            n_idx  = r_used[NW-1:0];
                            n_used = r_used + LW'(1);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                end
            end
            S_FREE: begin
                n_free_head = rd_next;
                n_idx       = to_idx(r_free_head);
            end
            S_INS: begin
                node_we    = 1'b1;
                node_waddr = r_idx;
                node_wdata = {r_key, r_val, r_head};
                bkt_we     = 1'b1;
                bkt_waddr  = r_bkt;
                bkt_wdata  = LW'(r_idx) + LW'(1);
                n_status   = ST_OK;
            end
            S_DEL1: begin
                // unlink: predecessor or bucket head skips the found node
                if (link_ok(r_prev)) begin
                    node_we    = 1'b1;
                    node_waddr = to_idx(r_prev);
                    node_wdata = {r_prev_word[NODE_W-1:LW], rd_next};
                end else begin
                    bkt_we    = 1'b1;
                    bkt_waddr = r_bkt;
                    bkt_wdata = rd_next;
                end
            end
            S_DEL2: begin
                node_we     = 1'b1;
                node_waddr  = to_idx(r_cur);
                node_wdata  = {rd_key, rd_val, r_free_head};
                n_free_head = r_cur;
                n_status    = ST_OK;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_vout   = r_vout;
                end
            end
            default: ;
        endcase
    end

    // memories; reads and writes never hit the same entry in one cycle, as writes
    // only happen in the clearing pass or after the walk is finished
    always_ff @(posedge i_clk) begin
        if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
        if (bkt_re) r_bkt_rd <= bkt_mem[bkt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) node_mem[node_waddr] <= node_wdata;
        if (node_re) r_node_rd <= node_mem[node_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free_head <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free_head <= n_free_head;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_val        <= n_val;
        r_bkt        <= n_bkt;
        r_quo        <= n_quo;
        r_bit        <= n_bit;
        r_head       <= n_head;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_prev_word  <= n_prev_word;
        r_steps      <= n_steps;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_vout       <= n_vout;
        r_out_status <= n_out_status;
        r_out_vout   <= n_out_vout;
    end

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= LW'(NODE_COUNT))
        else $error("bump pointer beyond pool");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("response loaded outside completion");

    a_free_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEL2 |=> r_free_head != '0 && r_free_head <= LW'(NODE_COUNT))
        else $error("freed node not on free list");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD || r_state == S_WALK) |-> !node_we && !bkt_we)
        else $error("memory write during chain walk");
`endif

endmodule

`default_nettype wire

// ===== sim/chained_hash_map_engine_core_tb.sv =====
// Self-checking testbench for the chained hash map engine: directed table, then random traffic.
module chained_hash_map_engine_core_tb
    import chme_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry matches the default build of the engine
    localparam int BUCKETS = BUCKET_COUNT_DEF;
    localparam int NODES   = NODE_COUNT_DEF;

    // Mode 3 has no name in the package; the engine answers it as not found
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int OPENING_OPS     = 25;
    localparam int RANDOM_OPS      = 825;
    localparam int PHASE_OPS       = 275;  // random transactions per idling phase
    localparam int FILL_OPS        = 560;  // insert-heavy stretch that drives the pool to full
    localparam int DRAIN_CYCLES    = 20;
    // Worst case between two handshakes: a walk over the whole pool plus a long
    // receiver stall, with a wide margin; also covers the clearing pass after reset
    localparam int WATCHDOG_CYCLES = 5000;

    typedef struct packed {
        bit [1:0]         status;
        bit [VALUE_W-1:0] value;
    } map_answer_t;

    typedef struct packed {
        bit [1:0]         mode;
        bit [KEY_W-1:0]   key;
        bit [VALUE_W-1:0] value;
        bit               typed;   // answer below is fixed; otherwise predicted
        map_answer_t      answer;
    } op_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    chme_req_if req_ch ();
    chme_rsp_if rsp_ch ();

    chained_hash_map_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the map: bucket heads, node pool, free list and bump
    // pointer. Links are node index + 1, zero meaning end of chain.
    // ------------------------------------------------------------------
    bit [8:0]         bucket_link [BUCKETS];
    bit [KEY_W-1:0]   slot_key    [NODES];
    bit [VALUE_W-1:0] slot_value  [NODES];
    bit [8:0]         slot_next   [NODES];
    bit [8:0]         free_link;
    int unsigned      fresh_slots;

    map_answer_t      pending_answers [$];   // oldest expected response first
    bit [KEY_W-1:0]   live_keys [$];         // keys currently held, for hits and duplicates

    int send_idle_pct;
    int take_idle_pct;
    int error_count;
    int sent_count;
    int checked_count;
    int status_seen [4];
    int quiet_cycles;

    // Directed opening: empty-map answers, extreme keys and values, a three-deep
    // chain in bucket 0 with hits at head, middle and tail, removal from the middle
    // and the head, refills from the free list and the unused mode
    op_row_t opening_ops [OPENING_OPS] = '{
        '{MODE_LOOKUP, 32'h0000_0000, 64'h0,                   1'b1, '{ST_MISS, 64'h0}},
        '{MODE_DELETE, 32'hFFFF_FFFF, 64'h0,                   1'b1, '{ST_MISS, 64'h0}},
        '{MODE_SPARE,  32'h0000_0005, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_MISS, 64'h0}},
        '{MODE_INSERT, 32'h0000_0000, 64'h0,                   1'b1, '{ST_OK,   64'h0}},
        '{MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK,   64'h0}},
        '{MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0,                   1'b1,
          '{ST_OK, 64'hFFFF_FFFF_FFFF_FFFF}},
        '{MODE_INSERT, 32'h0000_0000, 64'h1234,                1'b1, '{ST_DUP,  64'h0}},
        '{MODE_LOOKUP, 32'h0000_0000, 64'hDEAD,                1'b1, '{ST_OK,   64'h0}},
        '{MODE_INSERT, 32'h0000_0040, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '{ST_OK,   64'h0}},
        '{MODE_INSERT, 32'h0000_0080, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '{ST_OK,   64'h0}},
        '{MODE_LOOKUP, 32'h0000_0000, 64'h0,                   1'b0, '{ST_OK,   64'h0}},
        '{MODE_LOOKUP, 32'h0000_0040, 64'h0,                   1'b0, '{ST_OK,   64'h0}},
        '{MODE_LOOKUP, 32'h0000_00C0, 64'h0,                   1'b1, '{ST_MISS, 64'h0}},
        '{MODE_DELETE, 32'h0000_0040, 64'h0,                   1'b0, '{ST_OK,   64'h0}},
        '{MODE_LOOKUP, 32'h0000_0040, 64'h0,                   1'b1, '{ST_MISS, 64'h0}},
        '{MODE_DELETE, 32'h0000_0080, 64'h0,                   1'b0, '{ST_OK,   64'h0}},
        '{MODE_DELETE, 32'h0000_0000, 64'h0,                   1'b0, '{ST_OK,   64'h0}},
        '{MODE_LOOKUP, 32'h0000_0000, 64'h0,                   1'b1, '{ST_MISS, 64'h0}},
        '{MODE_INSERT, 32'h0000_00C0, 64'h8000_0000_0000_0001, 1'b0, '{ST_OK,   64'h0}},
        '{MODE_INSERT, 32'h0000_0100, 64'h0123_4567_89AB_CDEF, 1'b0, '{ST_OK,   64'h0}},
        '{MODE_INSERT, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '{ST_OK,   64'h0}},
        '{MODE_SPARE,  32'h0000_0000, 64'h0,                   1'b1, '{ST_MISS, 64'h0}},
        '{MODE_DELETE, 32'hFFFF_FFFF, 64'h0,                   1'b0, '{ST_OK,   64'h0}},
        '{MODE_LOOKUP, 32'h0000_00C0, 64'h0,                   1'b0, '{ST_OK,   64'h0}},
        '{MODE_DELETE, 32'h0000_0123, 64'h0,                   1'b1, '{ST_MISS, 64'h0}}
    };

    // Applies one operation to the shadow map and gives the engine's answer.
    // The chain walk stops at a link outside the pool or after a full pool of steps.
    task automatic map_apply(input bit [1:0] md, input bit [KEY_W-1:0] k,
                             input bit [VALUE_W-1:0] v, output map_answer_t ans);
        bit [5:0]    bkt;
        int unsigned steps;
        bit [7:0]    slot;
        bit [8:0]    link;
        bit [8:0]    prev_link;
        bit          hit;
        bit          got_slot;
        bkt       = 6'(k % BUCKETS);
        link      = bucket_link[bkt];
        prev_link = '0;
        hit       = 1'b0;
        steps     = 0;
        got_slot  = 1'b0;
        slot      = '0;
        while (!hit && steps < NODES && link != 0 && link <= NODES) begin
            slot = 8'(link - 9'd1);
            if (slot_key[slot] == k) begin
                hit = 1'b1;
            end else begin
                prev_link = link;
                link      = slot_next[slot];
                steps++;
            end
        end
        ans = '{ST_MISS, '0};
        case (md)
            MODE_INSERT: begin
                if (hit) begin
                    ans.status = ST_DUP;
                end else if (free_link != 0 && free_link <= NODES) begin
                    // free list first
                    slot      = 8'(free_link - 9'd1);
                    free_link = slot_next[slot];
                    got_slot  = 1'b1;
                end else if (fresh_slots < NODES) begin
                    slot     = 8'(fresh_slots);
                    fresh_slots++;
                    got_slot = 1'b1;
                end else begin
                    ans.status = ST_FULL;
                end
                if (got_slot) begin
                    slot_key[slot]    = k;
                    slot_value[slot]  = v;
                    slot_next[slot]   = bucket_link[bkt];
                    bucket_link[bkt]  = {1'b0, slot} + 9'd1;
                    ans.status        = ST_OK;
                end
            end
            MODE_LOOKUP: begin
                if (hit) ans = '{ST_OK, slot_value[slot]};
            end
            MODE_DELETE: begin
                if (hit) begin
                    if (prev_link != 0) slot_next[8'(prev_link - 9'd1)] = slot_next[slot];
                    else bucket_link[bkt] = slot_next[slot];
                    slot_next[slot] = free_link;
                    free_link       = {1'b0, slot} + 9'd1;
                    ans.status      = ST_OK;
                end
            end
            default: ;
        endcase
    endtask

    // Offers one request, waits for its handshake, then records what the
    // engine must answer. A typed row overrides the shadow map's answer,
    // though the shadow map still takes the operation.
    task automatic send_op(input bit [1:0] md, input bit [KEY_W-1:0] k,
                           input bit [VALUE_W-1:0] v, input bit typed,
                           input map_answer_t typed_ans);
        map_answer_t ans;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= md;
        req_ch.key      <= k;
        req_ch.value_in <= v;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_count++;
        map_apply(md, k, v, ans);
        pending_answers.push_back(typed ? typed_ans : ans);
        if (ans.status == ST_OK && md == MODE_INSERT) begin
            live_keys.push_back(k);
        end else if (ans.status == ST_OK && md == MODE_DELETE) begin
            foreach (live_keys[i]) begin
                if (live_keys[i] == k) begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    // Receiver: drops ready at random; the rate follows the current phase
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end

    // Response checker and watchdog. Both sample at the clock edge, so they
    // see the values that the handshake was judged on.
    always @(posedge i_clk) begin
        map_answer_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            checked_count++;
            status_seen[rsp_ch.status]++;
            if (pending_answers.size() == 0) begin
                $display("%0t: response with nothing outstanding: status %0d value %h",
                         $time, rsp_ch.status, rsp_ch.value_out);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.value_out !== want.value) begin
                    $display("%0t: value_out mismatch: expected %h, got %h",
                             $time, want.value, rsp_ch.value_out);
                    error_count++;
                end
            end
        end

        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, pending_answers.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Main sequence
    initial begin
        bit [1:0]         md;
        bit [KEY_W-1:0]   k;
        bit [VALUE_W-1:0] v;
        int               roll;
        int               reuse_pct;

        req_ch.valid    = 1'b0;
        req_ch.mode     = MODE_INSERT;
        req_ch.key      = '0;
        req_ch.value_in = '0;
        i_rst_n         = 1'b0;
        error_count     = 0;
        sent_count      = 0;
        checked_count   = 0;
        quiet_cycles    = 0;
        status_seen     = '{default: 0};
        bucket_link     = '{default: '0};
        free_link       = '0;
        fresh_slots     = 0;
        // phase 1: sender idles lightly, receiver heavily
        send_idle_pct   = 19;
        take_idle_pct   = 79;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass holds ready low; the handshake wait covers it

        foreach (opening_ops[i]) begin
            send_op(opening_ops[i].mode, opening_ops[i].key, opening_ops[i].value,
                    opening_ops[i].typed, opening_ops[i].answer);
        end

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == PHASE_OPS) begin
                // phase 2: roles swapped
                send_idle_pct = 79;
                take_idle_pct = 19;
            end else if (n == 2 * PHASE_OPS) begin
                // phase 3: back to back
                send_idle_pct = 0;
                take_idle_pct = 0;
            end

            // insert-heavy until the pool runs dry, then churn around full
            roll = $urandom_range(0, 99);
            if (n < FILL_OPS) begin
                md = (roll < 72) ? MODE_INSERT :
                     (roll < 86) ? MODE_LOOKUP :
                     (roll < 96) ? MODE_DELETE : MODE_SPARE;
            end else begin
                md = (roll < 35) ? MODE_INSERT :
                     (roll < 65) ? MODE_LOOKUP :
                     (roll < 96) ? MODE_DELETE : MODE_SPARE;
            end

            // held keys give hits and duplicates; fresh ones give misses and growth
            reuse_pct = (md == MODE_INSERT) ? 15 : 70;
            if (live_keys.size() != 0 && $urandom_range(0, 99) < reuse_pct) begin
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            end else begin
                k = $urandom;
            end
            v = {$urandom, $urandom};
            send_op(md, k, v, 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d map operations (%0d directed), %0d responses checked, %0d errors",
                 sent_count, OPENING_OPS, checked_count, error_count);
        $display("Answers: ok %0d, duplicate %0d, pool full %0d, not found %0d",
                 status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
                 status_seen[ST_MISS]);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/chme_pkg.sv
src/chme_req_if.sv
src/chme_rsp_if.sv
src/chained_hash_map_engine_core.sv
sim/chained_hash_map_engine_core_tb.sv
